// ===== rtl/ftn_pkg.sv =====
// ----------------------------------------------------------------------------
// ftn_pkg
// Shared constants, codes and types of the frequency table normalizer.
// ----------------------------------------------------------------------------
`default_nettype none
package ftn_pkg;
  localparam int ALPHABET_DEF  = 256;
  localparam int PROB_BITS_DEF = 24;
  localparam int CNT_W         = 32;
  localparam int SYM_W         = 8;
  localparam int SLOT_W        = 24;
  localparam int SUM_W         = 40;   // sum of up to 256 counts of 32 bits
  localparam int PROD_W        = 56;   // count times scale

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_NORM   = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_DECODE = 2'd3;

  typedef struct packed {
    logic start;
    logic [PROD_W-1:0] dividend;
    logic [SUM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/ftn_divider.sv =====
// ----------------------------------------------------------------------------
// ftn_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ftn_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ftn_pkg::div_req_t req,
  output ftn_pkg::div_rsp_t      rsp
);
  import ftn_pkg::*;
  localparam int CW = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [SUM_W:0]    rem_r, rem_nxt;
  logic [SUM_W-1:0]  div_r, div_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [SUM_W:0]    trial;

  always_comb begin
    quo_nxt = quo_r; rem_nxt = rem_r; div_nxt = div_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[SUM_W-1:0], quo_r[PROD_W-1]};
    if (req.start) begin
      quo_nxt = req.dividend; rem_nxt = '0; div_nxt = req.divisor;
      cnt_nxt = CW'(PROD_W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = trial - {1'b0, div_r};
        quo_nxt = {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt; rem_r <= rem_nxt; div_r <= div_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

// ===== rtl/frequency_table_normalizer.sv =====
// Frequency table of one range-ANS context row. Every item yields one result
// beat, and the next item is taken only once that beat has left. A lookup
// passes through one memory read, one register stage and the output
// register. Normalize walks the row in passes: it sums the counts, then per
// symbol a read, a multiply, a divider start and a wait on the single
// 56-step divider ending in the write, then it spreads the shortfall and
// builds starts. Decode scans the starts one entry a cycle. Counts clear
// after reset in a pass during which no item is taken.
`default_nettype none
module frequency_table_normalizer #(
  parameter int ALPHABET  = ftn_pkg::ALPHABET_DEF,
  parameter int PROB_BITS = ftn_pkg::PROB_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_symbol,
  input  wire logic [31:0] in_count,
  input  wire logic [23:0] in_slot,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [7:0]       out_out_symbol,
  output logic [23:0]      out_frequency,
  output logic [23:0]      out_start_res
);
  import ftn_pkg::*;
  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int IW = AW + 1;
  localparam logic [SUM_W-1:0] TOTAL = SUM_W'(1) << PROB_BITS;
  localparam logic [SUM_W-1:0] SCALE = TOTAL - SUM_W'(ALPHABET);
  localparam logic [SUM_W-1:0] EACH_E  = SCALE / SUM_W'(ALPHABET);
  localparam logic [SUM_W-1:0] EXTRA_E = SCALE % SUM_W'(ALPHABET);

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_LK = 4'd3,
                         S_SUM = 4'd4, S_DRD = 4'd5, S_DGO = 4'd6, S_DWT = 4'd7,
                         S_RRD = 4'd8, S_RWR = 4'd9, S_DEC = 4'd10, S_DLK = 4'd11,
                         S_OUT = 4'd12, S_NMUL = 4'd13;

  logic [CNT_W-1:0]     raw_mem [ALPHABET];
  logic [PROB_BITS-1:0] frq_mem [ALPHABET];
  logic [PROB_BITS-1:0] st_mem  [ALPHABET];

  logic [3:0] st_r, st_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic ready_r, ready_nxt;
  logic [1:0]  mode_r;
  logic [7:0]  sym_r;
  logic [23:0] slot_r;
  logic [SUM_W-1:0] sum_r, sum_nxt, dsum_r, dsum_nxt, acc_r, acc_nxt;
  logic [SUM_W-1:0] rest;
  logic [SUM_W-1:0] each_add, extra_lim;
  logic [PROD_W-1:0] prod_r;
  logic [CNT_W-1:0] raw_q;
  logic [PROB_BITS-1:0] frq_q, st_q;
  logic [AW-1:0] rd_a;
  logic raw_we, frq_we, st_we;
  logic [AW-1:0] wr_a;
  logic [CNT_W-1:0] raw_wd;
  logic [PROB_BITS-1:0] frq_wd, st_wd;
  logic [SUM_W-1:0] fadd;
  div_req_t dreq;
  div_rsp_t drsp;
  logic ov_r, ov_nxt, os_r, os_nxt;
  logic [7:0] osym_r, osym_nxt;
  logic [23:0] of_r, of_nxt, ost_r, ost_nxt;

  ftn_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign rest = (dsum_r <= TOTAL) ? TOTAL - dsum_r : '0;
  // shortfall stays below the alphabet size unless the row is empty
  assign each_add  = (rest >= SUM_W'(ALPHABET)) ? EACH_E : '0;
  assign extra_lim = (rest >= SUM_W'(ALPHABET)) ? EXTRA_E : rest;
  assign fadd = SUM_W'(frq_q) + each_add
              + ((SUM_W'(idx_r) < extra_lim) ? SUM_W'(1) : '0);
  assign in_stall = (st_r != S_IDLE) || ov_r;

  always_ff @(posedge clk) begin
    if (raw_we) raw_mem[wr_a] <= raw_wd;
    if (frq_we) frq_mem[wr_a] <= frq_wd;
    if (st_we)  st_mem[wr_a]  <= st_wd;
    raw_q <= raw_mem[rd_a];
    frq_q <= frq_mem[rd_a];
    st_q  <= st_mem[rd_a];
  end

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; ready_nxt = ready_r;
    sum_nxt = sum_r; dsum_nxt = dsum_r; acc_nxt = acc_r;
    rd_a = idx_r[AW-1:0]; wr_a = idx_r[AW-1:0];
    raw_we = 1'b0; frq_we = 1'b0; st_we = 1'b0;
    raw_wd = '0; frq_wd = '0; st_wd = '0;
    dreq.start = 1'b0; dreq.dividend = prod_r;
    dreq.divisor = (sum_r == '0) ? SUM_W'(1) : sum_r;
    ov_nxt = ov_r && out_stall; os_nxt = os_r; osym_nxt = osym_r;
    of_nxt = of_r; ost_nxt = ost_r;
    unique case (st_r)
      S_CLR: begin
        raw_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IW'(ALPHABET - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        rd_a = in_symbol[AW-1:0];
        if (in_valid && !in_stall) begin
          idx_nxt = '0; sum_nxt = '0; dsum_nxt = '0; acc_nxt = '0;
          unique case (in_mode)
            MODE_LOAD: begin
              if (32'(in_symbol) < 32'(ALPHABET)) begin
                raw_we = 1'b1; raw_wd = in_count; wr_a = in_symbol[AW-1:0];
                ready_nxt = 1'b0;
              end
              os_nxt = 1'b0; osym_nxt = in_symbol; of_nxt = '0; ost_nxt = '0;
              st_nxt = S_OUT;
            end
            MODE_NORM: st_nxt = S_SUM;
            MODE_LOOKUP: st_nxt = S_RD;
            MODE_DECODE: begin
              if (!ready_r) st_nxt = S_RD;
              else begin
                idx_nxt = IW'(1); st_nxt = S_DEC;
              end
            end
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        rd_a = sym_r[AW-1:0];
        st_nxt = S_LK;
      end
      S_LK: begin
        os_nxt = !ready_r;
        osym_nxt = (mode_r == MODE_DECODE) ? 8'd0 : sym_r;
        if (ready_r && 32'(sym_r) < 32'(ALPHABET)) begin
          of_nxt = 24'(frq_q); ost_nxt = 24'(st_q);
        end else begin
          of_nxt = '0; ost_nxt = '0;
        end
        st_nxt = S_OUT;
      end
      S_SUM: begin
        // raw_q comes from the address of the previous cycle
        if (idx_r != '0) sum_nxt = sum_r + SUM_W'(raw_q);
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IW'(ALPHABET)) begin
          idx_nxt = '0; st_nxt = S_DRD;
        end
      end
      S_DRD: st_nxt = S_NMUL;
      S_NMUL: st_nxt = S_DGO;
      S_DGO: begin
        dreq.start = 1'b1; st_nxt = S_DWT;
      end
      S_DWT: begin
        if (drsp.done) begin
          frq_we = 1'b1;
          frq_wd = PROB_BITS'(drsp.quotient + PROD_W'(1));
          dsum_nxt = dsum_r + SUM_W'(drsp.quotient) + SUM_W'(1);
          idx_nxt = idx_r + 1'b1;
          st_nxt = (idx_r == IW'(ALPHABET - 1)) ? S_RRD : S_DRD;
          if (idx_r == IW'(ALPHABET - 1)) idx_nxt = '0;
        end
      end
      S_RRD: st_nxt = S_RWR;
      S_RWR: begin
        frq_we = 1'b1; st_we = 1'b1;
        frq_wd = PROB_BITS'(fadd);
        st_wd = PROB_BITS'(acc_r);
        acc_nxt = acc_r + fadd;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IW'(ALPHABET - 1)) begin
          ready_nxt = 1'b1;
          os_nxt = 1'b0; osym_nxt = sym_r; of_nxt = '0; ost_nxt = '0;
          st_nxt = S_OUT;
        end else st_nxt = S_RRD;
      end
      S_DEC: begin
        // st_q holds start of idx_r-1 in the next cycle
        rd_a = AW'(idx_r - IW'(1));
        st_nxt = S_DLK;
      end
      S_DLK: begin
        if (24'(st_q) > slot_r) begin
          idx_nxt = idx_r - IW'(2); rd_a = idx_nxt[AW-1:0]; st_nxt = S_RD;
        end else if (idx_r == IW'(ALPHABET)) begin
          idx_nxt = IW'(ALPHABET - 1); rd_a = AW'(ALPHABET - 1); st_nxt = S_RD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
        if (st_nxt == S_RD) st_nxt = S_LK;
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_DLK && st_nxt == S_DLK) rd_a = idx_r[AW-1:0];
    if (st_r == S_SUM || st_r == S_DRD || st_r == S_RRD) rd_a = idx_r[AW-1:0];
  end

  // latch taken items; decode hit: keep the found symbol for the lookup stage
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_valid && !in_stall) begin
      mode_r <= in_mode; sym_r <= in_symbol; slot_r <= in_slot & 24'((TOTAL) - 1);
    end else if (st_r == S_DLK && st_nxt == S_LK) begin
      sym_r <= 8'(idx_nxt); mode_r <= MODE_LOOKUP;
    end
    if (st_r == S_NMUL) prod_r <= PROD_W'(raw_q) * PROD_W'(SCALE);
    sum_r <= sum_nxt; dsum_r <= dsum_nxt; acc_r <= acc_nxt;
    os_r <= os_nxt; osym_r <= osym_nxt; of_r <= of_nxt; ost_r <= ost_nxt;
    if (!rst_n) begin
      st_r <= S_CLR; idx_r <= '0; ready_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; ready_r <= ready_nxt; ov_r <= ov_nxt;
    end
  end

  assign out_valid      = ov_r;
  assign out_status     = os_r;
  assign out_out_symbol = osym_r;
  assign out_frequency  = of_r;
  assign out_start_res  = ost_r;
endmodule
`default_nettype wire

// ===== rtl/ftn_checker.sv =====
// ----------------------------------------------------------------------------
// ftn_checker
// Port-level checks of the frequency table normalizer.
// ----------------------------------------------------------------------------
`default_nettype none
module ftn_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_status,
  input wire logic [23:0] out_frequency,
  input wire logic [23:0] out_start_res
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frequency))
    else $error("stalled result changed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_frequency == 24'd0 && out_start_res == 24'd0)
    else $error("error result carries data");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too early");
endmodule

bind frequency_table_normalizer ftn_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_frequency(out_frequency), .out_start_res(out_start_res));
`default_nettype wire
